@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, codes and defaults for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

endpackage

@@ rtl/core/lfu_cache_table.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key/value cache, least-frequently-used eviction with least-recently-used
// tie break. Entries live in memories walked by one scan sequencer.
// A request is taken only when idle; it runs a scan pass over all entries,
// then a decide step that offers the result on m_tvalid, and for a hit or
// an insert a recency pass, before the next request is taken.
// A held result stalls the decide step until m_tready; both passes are bound
// by the single read port of the entry memories.
// Reset clears valid marks and occupancy and sets the capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int TABLE_ENTRIES = lfu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [63:0]               s_tdata,   // lookup_key, write_value
  input  logic [0:0]                s_tuser,   // command
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [63:0]               m_tdata,   // read_value, evicted_key
  output logic [1:0]                m_tuser    // hit, evicted
);

  localparam int N    = TABLE_ENTRIES;
  localparam int IW   = (N > 1) ? $clog2(N) : 1;
  localparam int CW   = $clog2(N + 1);
  localparam int CMPW = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
  localparam int KW   = lfu_pkg::KEY_W;
  localparam int VW   = lfu_pkg::VAL_W;
  localparam int NW   = lfu_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_RANK   = 2'd3;

  logic [1:0] state;

  logic [KW-1:0] key_mem  [N];
  logic [VW-1:0] val_mem  [N];
  logic [NW-1:0] cnt_mem  [N];
  logic [IW-1:0] rank_mem [N];
  logic [N-1:0]  valid;

  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic [NW-1:0] rd_cnt;
  logic [IW-1:0] rd_rank;

  logic [lfu_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0] occ;

  logic          cmd_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;

  logic [CW-1:0] cnt;
  logic          pend;
  logic [IW-1:0] pidx;

  logic          found;
  logic [IW-1:0] midx;
  logic [IW-1:0] mrank;
  logic [NW-1:0] mcnt;
  logic [VW-1:0] mval;
  logic          vfound;
  logic [IW-1:0] vidx;
  logic [IW-1:0] vrank;
  logic [NW-1:0] vcnt;
  logic [KW-1:0] vkey;
  logic          ffound;
  logic [IW-1:0] fidx;

  logic [IW-1:0] tgt;
  logic [IW-1:0] rref;
  logic          rall;

  logic          out_hit;
  logic          out_ev;
  logic [VW-1:0] out_rd;
  logic [KW-1:0] out_evkey;

  logic [IW-1:0]   raddr;
  logic [CMPW-1:0] cap_eff;
  logic            evict_c;
  logic [IW-1:0]   slot_c;
  logic [NW-1:0]   count_inc;
  logic            do_hit_upd;
  logic            do_insert;
  logic            go;
  logic [IW-1:0]   wa;
  logic            key_we;
  logic            val_we;
  logic            cnt_we;
  logic [NW-1:0]   cnt_wd;
  logic [VW-1:0]   val_wd;
  logic            rank_we;
  logic [IW-1:0]   rank_wd;
  logic            scan_end;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {out_evkey, out_rd};
  assign m_tuser  = {out_ev, out_hit};
  assign raddr    = cnt[IW-1:0];
  assign scan_end = (cnt == CW'(N)) && pend;

  always_comb begin
    cap_eff = (CMPW'(capacity) > CMPW'(N)) ? CMPW'(N) : CMPW'(capacity);
    evict_c = vfound && (CMPW'(occ) >= cap_eff);
    slot_c  = (ffound && (!evict_c || (fidx < vidx))) ? fidx : vidx;
    count_inc  = (mcnt == lfu_pkg::COUNT_MAX) ? mcnt : mcnt + lfu_pkg::COUNT_ONE;
    do_hit_upd = found && ((cmd_r == lfu_pkg::CMD_GET) || (cap_eff != '0));
    do_insert  = (cmd_r == lfu_pkg::CMD_PUT) && (cap_eff != '0) && !found;
    go     = (state == ST_DECIDE) && (!m_tvalid || m_tready);
    wa     = do_insert ? slot_c : midx;
    key_we = go && do_insert;
    val_we = go && (cmd_r == lfu_pkg::CMD_PUT) && (do_insert || do_hit_upd);
    cnt_we = go && (do_insert || do_hit_upd);
    cnt_wd = do_insert ? lfu_pkg::COUNT_ONE : count_inc;
    val_wd = val_r;
    rank_we = (state == ST_RANK) && pend &&
              ((pidx == tgt) || (valid[pidx] && (rall || (rd_rank < rref))));
    rank_wd = (pidx == tgt) ? '0 : rd_rank + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wa] <= key_r;
    if (val_we) val_mem[wa] <= val_wd;
    if (cnt_we) cnt_mem[wa] <= cnt_wd;
    rd_key <= key_mem[raddr];
    rd_val <= val_mem[raddr];
    rd_cnt <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[pidx] <= rank_wd;
    rd_rank <= rank_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      occ      <= '0;
      capacity <= lfu_pkg::CAP_RESET;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_write) capacity <= cfg_data;
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state) inside
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_r  <= s_tuser[0];
            key_r  <= s_tdata[KW-1:0];
            val_r  <= s_tdata[KW+VW-1:KW];
            found  <= 1'b0;
            vfound <= 1'b0;
            ffound <= 1'b0;
            cnt    <= '0;
            pend   <= 1'b0;
            state  <= ST_SCAN;
          end
        end

        ST_SCAN, ST_RANK: begin
          if (cnt != CW'(N)) begin
            pend <= 1'b1;
            pidx <= cnt[IW-1:0];
            cnt  <= cnt + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (state == ST_SCAN && pend) begin
            if (valid[pidx]) begin
              if (!found && rd_key == key_r) begin
                found <= 1'b1;
                midx  <= pidx;
                mrank <= rd_rank;
                mcnt  <= rd_cnt;
                mval  <= rd_val;
              end
              if (!vfound || rd_cnt < vcnt || (rd_cnt == vcnt && rd_rank > vrank)) begin
                vfound <= 1'b1;
                vidx   <= pidx;
                vrank  <= rd_rank;
                vcnt   <= rd_cnt;
                vkey   <= rd_key;
              end
            end else if (!ffound) begin
              ffound <= 1'b1;
              fidx   <= pidx;
            end
          end
          if (scan_end) begin
            state <= (state == ST_SCAN) ? ST_DECIDE : ST_IDLE;
          end
        end

        ST_DECIDE: begin
          if (go) begin
            out_hit   <= do_hit_upd;
            out_rd    <= (cmd_r == lfu_pkg::CMD_GET && found) ? mval : '0;
            out_ev    <= do_insert && evict_c;
            out_evkey <= (do_insert && evict_c) ? vkey : '0;
            tgt  <= wa;
            rref <= found ? mrank : vrank;
            rall <= do_insert && !evict_c;
            cnt  <= '0;
            pend <= 1'b0;
            if (do_insert) begin
              if (evict_c) valid[vidx] <= 1'b0;
              else         occ <= occ + CW'(1);
              valid[slot_c] <= 1'b1;
            end
            state <= (do_insert || do_hit_upd) ? ST_RANK : ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives get and put transactions into the LFU cache table and checks every
// result against a cycle-free model of the table kept in the bench. The run
// covers directed corner cases: empty table, key and value extremes, zero
// capacity, clamped capacity and capacity lowered below the fill level. It
// then runs random traffic phases over several capacities, with bursty input
// and random output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ENTRIES       = lfu_pkg::TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
  localparam int POOL_SIZE     = 32;

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::KEY_W-1:0] evicted_key;
  } access_result_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [lfu_pkg::CAP_W-1:0] cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic [63:0]               s_tdata   = '0;   // lookup_key, write_value
  logic [0:0]                s_tuser   = '0;   // command
  logic                      m_tready  = 1'b0;
  wire                       s_tready;
  wire                       m_tvalid;
  wire  [63:0]               m_tdata;          // read_value, evicted_key
  wire  [1:0]                m_tuser;          // hit, evicted

  lfu_cache_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [lfu_pkg::CAP_W-1:0] capacity_reg = lfu_pkg::CAP_RESET;
  logic                      cache_valid [ENTRIES];
  logic [lfu_pkg::KEY_W-1:0] cache_key   [ENTRIES];
  logic [lfu_pkg::VAL_W-1:0] cache_value [ENTRIES];
  logic [lfu_pkg::CNT_W-1:0] cache_uses  [ENTRIES];
  int                        cache_age   [ENTRIES];
  int                        cache_fill  = 0;

  access_result_t            pending_results [$];
  access_result_t            oldest_result;
  logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  int error_count     = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  int stall_left      = 0;
  bit sender_gaps_on  = 1'b1;
  bit ready_stalls_on = 1'b1;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("[%0t] %s mismatch: got %h expected %h", $time, field, got, want);
  endtask

  // Bump the use count (saturating) and move the entry to the front of the age order.
  task automatic refresh_entry(input int idx);
    int old_age;
    old_age = cache_age[idx];
    if (cache_uses[idx] != lfu_pkg::COUNT_MAX)
      cache_uses[idx] = cache_uses[idx] + 1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_valid[i] && i != idx && cache_age[i] < old_age)
        cache_age[i]++;
    end
    cache_age[idx] = 0;
  endtask

  task automatic predict_access(input logic cmd, input logic [lfu_pkg::KEY_W-1:0] key,
                                input logic [lfu_pkg::VAL_W-1:0] val,
                                output access_result_t res);
    int limit_eff;
    int found;
    int victim;
    int slot;
    int gone_age;
    res = '0;
    limit_eff = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
    found = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && cache_valid[i] && cache_key[i] == key)
        found = i;
    end
    if (cmd == lfu_pkg::CMD_GET) begin
      if (found >= 0) begin
        refresh_entry(found);
        res.hit = 1'b1;
        res.read_value = cache_value[found];
      end
    end else if (limit_eff != 0) begin
      if (found >= 0) begin
        cache_value[found] = val;
        refresh_entry(found);
        res.hit = 1'b1;
      end else begin
        if (cache_fill >= limit_eff) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i] && (victim < 0 || cache_uses[i] < cache_uses[victim] ||
                (cache_uses[i] == cache_uses[victim] && cache_age[i] > cache_age[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = cache_key[victim];
            cache_valid[victim] = 1'b0;
            gone_age = cache_age[victim];
            for (int i = 0; i < ENTRIES; i++) begin
              if (cache_valid[i] && cache_age[i] > gone_age)
                cache_age[i]--;
            end
            if (cache_fill > 0)
              cache_fill--;
          end
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !cache_valid[i])
            slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (cache_valid[i])
              cache_age[i]++;
          end
          cache_valid[slot] = 1'b1;
          cache_key[slot]   = key;
          cache_value[slot] = val;
          cache_uses[slot]  = lfu_pkg::COUNT_ONE;
          cache_age[slot]   = 0;
          cache_fill++;
        end
      end
    end
  endtask

  task automatic send_access(input logic cmd, input logic [lfu_pkg::KEY_W-1:0] key,
                             input logic [lfu_pkg::VAL_W-1:0] val);
    access_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = 0;
      if (sender_gaps_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {val, key};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    predict_access(cmd, key, val, res);
    pending_results.insert(pending_results.size(), res);
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic test_basic_access();
    send_access(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_access(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_access(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_access(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(lfu_pkg::CMD_GET, 32'h0000_0005, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_capacity();
    set_capacity(5'd0);
    send_access(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0001);
    send_access(lfu_pkg::CMD_PUT, 32'h0000_004D, 32'h0000_0002);
    send_access(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_clamp_and_shrink();
    set_capacity(5'd17);
    repeat (15) send_access(lfu_pkg::CMD_PUT, $urandom, $urandom);
    set_capacity(5'd2);
    send_access(lfu_pkg::CMD_PUT, $urandom, $urandom);
    send_access(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(input logic [lfu_pkg::CAP_W-1:0] cap, input int count,
                                     input bit gaps, input bit stalls);
    int limit_eff;
    int window;
    logic cmd;
    logic [lfu_pkg::KEY_W-1:0] key;
    logic [lfu_pkg::VAL_W-1:0] val;
    set_capacity(cap);
    sender_gaps_on  = gaps;
    ready_stalls_on = stalls;
    limit_eff = (cap > ENTRIES) ? ENTRIES : int'(cap);
    window = ((limit_eff == 0) ? ENTRIES : limit_eff) + 1 + $urandom_range(0, 5);
    repeat (count) begin
      cmd = ($urandom_range(0, 99) < 45) ? lfu_pkg::CMD_PUT : lfu_pkg::CMD_GET;
      key = ($urandom_range(0, 7) == 0) ? $urandom : key_pool[$urandom_range(0, window - 1)];
      case ($urandom_range(0, 7))
        0: val = '0;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'h8000_0000;
        3: val = '1;
        default: val = $urandom;
      endcase
      send_access(cmd, key, val);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (ready_stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 20);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        if (m_tuser[0] !== oldest_result.hit)
          report_mismatch("hit", 64'(m_tuser[0]), 64'(oldest_result.hit));
        if (m_tdata[31:0] !== oldest_result.read_value)
          report_mismatch("read_value", 64'(m_tdata[31:0]), 64'(oldest_result.read_value));
        if (m_tuser[1] !== oldest_result.evicted)
          report_mismatch("evicted", 64'(m_tuser[1]), 64'(oldest_result.evicted));
        if (m_tdata[63:32] !== oldest_result.evicted_key)
          report_mismatch("evicted_key", 64'(m_tdata[63:32]),
                          64'(oldest_result.evicted_key));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lfu_cache_table verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i]   = '0;
      cache_value[i] = '0;
      cache_uses[i]  = '0;
      cache_age[i]   = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_access();
    test_zero_capacity();
    test_clamp_and_shrink();
    test_random_traffic(5'd1,  210, 1'b1, 1'b1);
    test_random_traffic(5'd31, 210, 1'b1, 1'b0);
    test_random_traffic(5'd4,  210, 1'b0, 1'b1);
    test_random_traffic(5'd0,  200, 1'b1, 1'b1);
    test_random_traffic(5'd16, 210, 1'b0, 1'b0);
    test_random_traffic(5'd2,  210, 1'b1, 1'b1);
    test_random_traffic(5'd9,  210, 1'b1, 1'b1);
    test_random_traffic(5'($urandom_range(3, 30)), 260, 1'b1, 1'b1);

    wait_idle();
    if (error_count == 0)
      $display("lfu_cache_table verification clean");
    else
      $display("lfu_cache_table verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lfu_pkg.sv
rtl/core/lfu_cache_table.sv
dv/testbench.sv
